// File: rtl/avr_pkg.sv
// Package: shared constants, types and the arctangent table for the axis-angle rotator.
`default_nettype none
package avr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [25:0] ONE_Q24 = 26'sd16777216;
    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic               zero;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [17:0] ax;
        logic signed [17:0] ay;
        logic signed [17:0] az;
    } t_side;

    function automatic logic signed [32:0] atan_lut(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:  v = 33'sd536870912;
            5'd1:  v = 33'sd316933406;
            5'd2:  v = 33'sd167458907;
            5'd3:  v = 33'sd85004756;
            5'd4:  v = 33'sd42667331;
            5'd5:  v = 33'sd21354465;
            5'd6:  v = 33'sd10679838;
            5'd7:  v = 33'sd5340245;
            5'd8:  v = 33'sd2670163;
            5'd9:  v = 33'sd1335087;
            5'd10: v = 33'sd667544;
            5'd11: v = 33'sd333772;
            5'd12: v = 33'sd166886;
            5'd13: v = 33'sd83443;
            5'd14: v = 33'sd41722;
            5'd15: v = 33'sd20861;
            5'd16: v = 33'sd10430;
            5'd17: v = 33'sd5215;
            5'd18: v = 33'sd2608;
            5'd19: v = 33'sd1304;
            5'd20: v = 33'sd652;
            5'd21: v = 33'sd326;
            5'd22: v = 33'sd163;
            5'd23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/avr_cordic.sv
// Pipelined CORDIC: cosine and sine in Q.24 of a binary angle, one iteration per stage.
`default_nettype none
module avr_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [15:0]        i_angle,
    input  wire avr_pkg::t_side     i_side,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [25:0]      o_cos,
    output logic signed [25:0]      o_sin,
    output avr_pkg::t_side          o_side
);
    localparam int N = avr_pkg::NSTEPS + 2;
    localparam int L = avr_pkg::NSTEPS;

    logic               r_vld [N];
    logic               en    [N];
    logic signed [33:0] r_x   [L+1];
    logic signed [33:0] r_y   [L+1];
    logic signed [32:0] r_z   [L+1];
    logic               r_flip[L+1];
    avr_pkg::t_side     r_sd  [L+1];
    logic signed [25:0] r_cos;
    logic signed [25:0] r_sin;
    avr_pkg::t_side     r_osd;
    logic [15:0]        fold;
    logic signed [33:0] xf;
    logic signed [33:0] yf;
    logic signed [27:0] rx;
    logic signed [27:0] ry;

    always_comb begin
        en[N-1] = !r_vld[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // fold into the half turn about zero
    assign fold = {i_angle[15] ^ (i_angle[15] ^ i_angle[14]), i_angle[14:0]};

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x[0]    <= avr_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= {fold[15], fold, 16'b0};
            r_flip[0] <= i_angle[15] ^ i_angle[14];
            r_sd[0]   <= i_side;
        end
    end

    for (genvar k = 0; k < L; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (en[k+1]) begin
                if (!r_z[k][32]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - avr_pkg::atan_lut(5'(k));
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + avr_pkg::atan_lut(5'(k));
                end
                r_flip[k+1] <= r_flip[k];
                r_sd[k+1]   <= r_sd[k];
            end
        end
    end

    always_comb begin
        xf = r_flip[L] ? -r_x[L] : r_x[L];
        yf = r_flip[L] ? -r_y[L] : r_y[L];
        rx = 28'((xf + 34'sd32) >>> 6);
        ry = 28'((yf + 34'sd32) >>> 6);
    end

    always_ff @(posedge i_clk) begin
        if (en[N-1]) begin
            if (rx > 28'(avr_pkg::ONE_Q24))       r_cos <= avr_pkg::ONE_Q24;
            else if (rx < -28'(avr_pkg::ONE_Q24)) r_cos <= -avr_pkg::ONE_Q24;
            else                                  r_cos <= 26'(rx);
            if (ry > 28'(avr_pkg::ONE_Q24))       r_sin <= avr_pkg::ONE_Q24;
            else if (ry < -28'(avr_pkg::ONE_Q24)) r_sin <= -avr_pkg::ONE_Q24;
            else                                  r_sin <= 26'(ry);
            r_osd <= r_sd[L];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
    assign o_side  = r_osd;

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cos <= avr_pkg::ONE_Q24 && o_cos >= -avr_pkg::ONE_Q24))
        else $error("cosine out of range");
    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sin <= avr_pkg::ONE_Q24 && o_sin >= -avr_pkg::ONE_Q24))
        else $error("sine out of range");
endmodule
`default_nettype wire

// File: rtl/avr_matrix.sv
// Rotation matrix build: nine Q.24 terms from cosine, sine and the axis, three stages.
`default_nettype none
module avr_matrix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [25:0] i_cos,
    input  wire logic signed [25:0] i_sin,
    input  wire avr_pkg::t_side     i_side,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_m [9],
    output avr_pkg::t_side          o_side
);
    logic               r_vld [3];
    logic               en    [3];
    logic signed [26:0] omc;
    logic signed [44:0] r_tx, r_ty, r_tz;
    logic signed [43:0] r_sx, r_sy, r_sz, r2_sx, r2_sy, r2_sz;
    logic signed [25:0] r_c, r2_c;
    avr_pkg::t_side     r_sd1, r_sd2, r_sd3;
    logic signed [62:0] r_pxx, r_pxy, r_pxz, r_pyy, r_pyz, r_pzz;
    logic signed [63:0] one56, sx16, sy16, sz16;
    logic signed [63:0] m [9];
    logic signed [31:0] r_m [9];

    always_comb begin
        en[2] = !r_vld[2] || !i_stall;
        en[1] = !r_vld[1] || en[2];
        en[0] = !r_vld[0] || en[1];
    end
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_vld[k] <= 1'b0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    assign omc = 27'(avr_pkg::ONE_Q24) - 27'(i_cos);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tx  <= 45'(i_side.ax) * 45'(omc);
            r_ty  <= 45'(i_side.ay) * 45'(omc);
            r_tz  <= 45'(i_side.az) * 45'(omc);
            r_sx  <= 44'(i_side.ax) * 44'(i_sin);
            r_sy  <= 44'(i_side.ay) * 44'(i_sin);
            r_sz  <= 44'(i_side.az) * 44'(i_sin);
            r_c   <= i_cos;
            r_sd1 <= i_side;
        end
        if (en[1]) begin
            r_pxx <= 63'(r_tx) * 63'(r_sd1.ax);
            r_pxy <= 63'(r_tx) * 63'(r_sd1.ay);
            r_pxz <= 63'(r_tx) * 63'(r_sd1.az);
            r_pyy <= 63'(r_ty) * 63'(r_sd1.ay);
            r_pyz <= 63'(r_ty) * 63'(r_sd1.az);
            r_pzz <= 63'(r_tz) * 63'(r_sd1.az);
            r2_sx <= r_sx;
            r2_sy <= r_sy;
            r2_sz <= r_sz;
            r2_c  <= r_c;
            r_sd2 <= r_sd1;
        end
    end

    always_comb begin
        one56 = {{6{r2_c[25]}}, r2_c, 32'b0};
        sx16  = {{4{r2_sx[43]}}, r2_sx, 16'b0};
        sy16  = {{4{r2_sy[43]}}, r2_sy, 16'b0};
        sz16  = {{4{r2_sz[43]}}, r2_sz, 16'b0};
        m[0] = one56 + 64'(r_pxx);
        m[1] = 64'(r_pxy) - sz16;
        m[2] = 64'(r_pxz) + sy16;
        m[3] = 64'(r_pxy) + sz16;
        m[4] = one56 + 64'(r_pyy);
        m[5] = 64'(r_pyz) - sx16;
        m[6] = 64'(r_pxz) - sy16;
        m[7] = 64'(r_pyz) + sx16;
        m[8] = one56 + 64'(r_pzz);
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= 32'((m[k] + 64'sh80000000) >>> 32);
            end
            r_sd3 <= r_sd2;
        end
    end

    assign o_valid = r_vld[2];
    assign o_m     = r_m;
    assign o_side  = r_sd3;
endmodule
`default_nettype wire

// File: rtl/avr_apply.sv
// Matrix times vector, rounding to Q16.16 and saturation; ends in the output register.
`default_nettype none
module avr_apply (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_m [9],
    input  wire avr_pkg::t_side     i_side,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_x,
    output logic signed [31:0]      o_y,
    output logic signed [31:0]      o_z,
    output logic                    o_sat
);
    logic               r_vld [2];
    logic               en    [2];
    logic signed [63:0] r_p [9];
    avr_pkg::t_side     r_sd;
    logic signed [63:0] acc [3];
    logic signed [39:0] rr  [3];
    logic signed [31:0] sv  [3];
    logic signed [31:0] pv  [3];
    logic [2:0]         clip;
    logic signed [31:0] r_o [3];
    logic               r_sat;

    always_comb begin
        en[1] = !r_vld[1] || !i_stall;
        en[0] = !r_vld[0] || en[1];
    end
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int r = 0; r < 3; r++) begin
                r_p[3*r]   <= 64'(i_m[3*r])   * 64'(i_side.vx);
                r_p[3*r+1] <= 64'(i_m[3*r+1]) * 64'(i_side.vy);
                r_p[3*r+2] <= 64'(i_m[3*r+2]) * 64'(i_side.vz);
            end
            r_sd <= i_side;
        end
    end

    always_comb begin
        pv[0] = r_sd.vx;
        pv[1] = r_sd.vy;
        pv[2] = r_sd.vz;
        for (int r = 0; r < 3; r++) begin
            acc[r] = r_p[3*r] + r_p[3*r+1] + r_p[3*r+2] + 64'sh800000;
            rr[r]  = 40'(acc[r] >>> 24);
            clip[r] = 1'b0;
            if (rr[r] > 40'(avr_pkg::SAT_MAX)) begin
                sv[r] = avr_pkg::SAT_MAX;
                clip[r] = 1'b1;
            end else if (rr[r] < 40'(avr_pkg::SAT_MIN)) begin
                sv[r] = avr_pkg::SAT_MIN;
                clip[r] = 1'b1;
            end else begin
                sv[r] = 32'(rr[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int r = 0; r < 3; r++) r_o[r] <= r_sd.zero ? pv[r] : sv[r];
            r_sat <= !r_sd.zero && (|clip);
        end
    end

    assign o_valid = r_vld[1];
    assign o_x     = r_o[0];
    assign o_y     = r_o[1];
    assign o_z     = r_o[2];
    assign o_sat   = r_sat;
endmodule
`default_nettype wire

// File: rtl/axis_angle_vector_rotate_core.sv
// Top level of the axis-angle (Rodrigues) vector rotator.
// Input channel: i_valid / o_stall with vector (Q16.16), unit axis (Q1.16)
// and a binary angle (65536 per turn). A beat is taken when i_valid is high
// and o_stall is low.
// Output channel: o_valid / i_stall with the rotated vector (Q16.16) and a
// saturated flag; a beat leaves when o_valid is high and i_stall is low.
// Path: sine/cosine pipeline (input register, a register per CORDIC step,
// output register), matrix build, then apply and saturate. Throughput:
// one beat per cycle unless stalled; every stage is a register.
// Angle zero passes the vector through with the flag clear.
// Reset (synchronous, active low) empties every stage; nothing is lost in
// flight semantics beyond that. When the receiver stalls, the output beat
// holds and upstream stages keep filling any empty slot; o_stall rises
// only once the pipeline is full back to the input.
`default_nettype none
module axis_angle_vector_rotate_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [17:0] i_axis_x,
    input  wire logic signed [17:0] i_axis_y,
    input  wire logic signed [17:0] i_axis_z,
    input  wire logic [15:0]        i_turn_angle,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic                    o_saturated
);
    avr_pkg::t_side     side_in, side_c, side_m;
    logic               vld_c, stall_c, vld_m, stall_m;
    logic signed [25:0] cos_c, sin_c;
    logic signed [31:0] mat [9];

    always_comb begin
        side_in.zero = (i_turn_angle == 16'd0);
        side_in.vx   = i_vec_x;
        side_in.vy   = i_vec_y;
        side_in.vz   = i_vec_z;
        side_in.ax   = i_axis_x;
        side_in.ay   = i_axis_y;
        side_in.az   = i_axis_z;
    end

    avr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_angle (i_turn_angle),
        .i_side  (side_in),
        .o_valid (vld_c),
        .i_stall (stall_c),
        .o_cos   (cos_c),
        .o_sin   (sin_c),
        .o_side  (side_c)
    );

    avr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_c),
        .o_stall (stall_c),
        .i_cos   (cos_c),
        .i_sin   (sin_c),
        .i_side  (side_c),
        .o_valid (vld_m),
        .i_stall (stall_m),
        .o_m     (mat),
        .o_side  (side_m)
    );

    avr_apply u_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vld_m),
        .o_stall (stall_m),
        .i_m     (mat),
        .i_side  (side_m),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_sat   (o_saturated)
    );

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_x == avr_pkg::SAT_MAX || o_out_x == avr_pkg::SAT_MIN ||
             o_out_y == avr_pkg::SAT_MAX || o_out_y == avr_pkg::SAT_MIN ||
             o_out_z == avr_pkg::SAT_MAX || o_out_z == avr_pkg::SAT_MIN))
        else $error("saturated flag without a clipped component");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");
endmodule
`default_nettype wire

// File: dv/axis_angle_vector_rotate_core_tb.sv
// Testbench for the axis-angle vector rotator: predicts each rotated beat and checks it.
`default_nettype none
module axis_angle_vector_rotate_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_rot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic signed [17:0] i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic [15:0] i_turn_angle = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic o_saturated;

    t_rot rotated_q[$];
    int mismatches = 0;
    int cycles = 0;
    int idle_left = 0;
    logic hold_on = 1'b0;
    event hold_go;
    localparam int LATENCY = avr_pkg::NSTEPS + 7;
    localparam int CYCLE_LIMIT = 400000;

    axis_angle_vector_rotate_core uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd64(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip_one(longint v);
        if (v > 16777216) return 16777216;
        if (v < -16777216) return -16777216;
        return v;
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
        longint a, x, y, z, dx, dy;
        longint steps_atan [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        bit flip;
        a = longint'($signed(ang));
        flip = 0;
        if (a >= 16384 || a < -16384) begin
            a = longint'($signed(16'(a + 32768)));
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < avr_pkg::NSTEPS; i++) begin
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= steps_atan[i];
            end else begin
                x += dx; y -= dy; z += steps_atan[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = clip_one(rnd64(x, 6));
        s = clip_one(rnd64(y, 6));
    endtask

    task automatic rotate_vector(input logic signed [31:0] vx, vy, vz,
                                 input logic signed [17:0] ax, ay, az,
                                 input logic [15:0] ang, output t_rot r);
        longint v[3], a[3], m[3][3], c, s, omc, one56, acc;
        v = '{vx, vy, vz};
        a = '{ax, ay, az};
        r.sat = 0;
        if (ang == 0) begin
            r.x = vx; r.y = vy; r.z = vz;
            return;
        end
        sin_cos(ang, c, s);
        omc = 16777216 - c;
        one56 = c * (longint'(1) << 32);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = a[i] * a[j] * omc + ((i == j) ? one56 : 0);
        m[0][1] -= a[2] * s * 65536; m[1][0] += a[2] * s * 65536;
        m[0][2] += a[1] * s * 65536; m[2][0] -= a[1] * s * 65536;
        m[1][2] -= a[0] * s * 65536; m[2][1] += a[0] * s * 65536;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += rnd64(m[i][j], 32) * v[j];
            acc = rnd64(acc, 24);
            if (acc > 64'sh7fffffff) begin
                acc = 64'sh7fffffff; r.sat = 1;
            end else if (acc < -64'sh80000000) begin
                acc = -64'sh80000000; r.sat = 1;
            end
            if (i == 0) r.x = acc[31:0];
            else if (i == 1) r.y = acc[31:0];
            else r.z = acc[31:0];
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_beat(input logic signed [31:0] vx, vy, vz,
                             input logic signed [17:0] ax, ay, az, input logic [15:0] ang);
        t_rot r;
        int g;
        rotate_vector(vx, vy, vz, ax, ay, az, ang, r);
        i_valid <= 1'b1;
        i_vec_x <= vx; i_vec_y <= vy; i_vec_z <= vz;
        i_axis_x <= ax; i_axis_y <= ay; i_axis_z <= az;
        i_turn_angle <= ang;
        do @(posedge i_clk); while (o_stall);
        rotated_q.push_back(r);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [17:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_vec();
        case ($urandom_range(0, 4))
            0: return 32'($urandom);
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] angs[10] = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd32768,
                                  16'd49151, 16'd49152, 16'd65535, 16'd8192, 16'd40000};
        foreach (angs[k])
            send_beat(32'sh00010000, 32'sh00020000, -32'sh00030000,
                      18'sd0, 18'sd0, 18'sd65536, angs[k]);
        send_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  18'sd65536, 18'sd65536, 18'sd65536, 16'd8192);
        send_beat(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  18'sh20000, 18'sd131071, 18'sh20000, 16'd20000);
        send_beat(32'sh80000000, 32'sh7fffffff, 32'sh0, 18'sd65536, 18'sd0, 18'sd0, 16'd0);
        send_beat(32'shffffffff, 32'sh0, 32'sh1, 18'sd131071, -18'sd1, 18'sd0, 16'd32768);
        send_beat(32'sh12345678, -32'sh1234567, 32'sh0, 18'sd46341, 18'sd46341, 18'sd0, 16'd1);
    endtask

    task automatic test_back_pressure();
        -> hold_go;
        for (int k = 0; k < 60; k++)
            send_beat(pick_vec(), pick_vec(), pick_vec(), pick_axis(), pick_axis(),
                      pick_axis(), 16'($urandom));
    endtask

    task automatic test_random();
        for (int k = 0; k < 870; k++)
            send_beat(pick_vec(), pick_vec(), pick_vec(), pick_axis(), pick_axis(),
                      pick_axis(), ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom));
    endtask

    // long receiver hold-off, counted in cycles
    always begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_on) i_stall <= 1'b1;
        else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            idle_left <= gap_len();
            i_stall <= 1'b1;
        end else i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotated_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected beat %h %h %h", o_out_x, o_out_y, o_out_z);
            end else begin
                t_rot e;
                e = rotated_q.pop_front();
                if (e.x !== o_out_x || e.y !== o_out_y || e.z !== o_out_z
                        || e.sat !== o_saturated) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp %h %h %h %b got %h %h %h %b", e.x, e.y, e.z,
                                 e.sat, o_out_x, o_out_y, o_out_z, o_saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_random();
        i_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && rotated_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/avr_pkg.sv
rtl/avr_cordic.sv
rtl/avr_matrix.sv
rtl/avr_apply.sv
rtl/axis_angle_vector_rotate_core.sv
dv/axis_angle_vector_rotate_core_tb.sv
